### design/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants of the tap tempo estimator
// Field widths, register indexes, reset values, status codes and the
// command bundle between the sequencer and the timestamp window.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

    // field widths
    localparam int TIME_W    = 32;
    localparam int BPM_W     = 24;
    localparam int STAT_W    = 2;
    localparam int TAPS_W    = 5;
    localparam int FRAC_BITS = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPM     = 1'd1;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd2000000;
    localparam logic [TIME_W-1:0] TPM_RST     = 32'd60000000;

    // window depth default
    localparam int MAX_TAPS_DEF = 8;

    // result status codes
    localparam logic [STAT_W-1:0] ST_NEED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_VALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd2;

    localparam logic [BPM_W-1:0] BPM_MAX = {BPM_W{1'b1}};

    // commands from the sequencer to the window
    typedef struct packed {
        logic rd_newest;
        logic rd_oldest;
        logic push;
        logic clear;
    } t_win_cmd;

endpackage

`default_nettype wire

### design/tap_tempo_estimator.sv
// ----------------------------------------------------------------------------
// tap_tempo_estimator: tap-tempo BPM estimator in Q8 fixed point
// Each tap timestamp updates a window of recent taps and yields one tempo
// result: ticks_per_minute * (n-1) * 256 / (newest - oldest), saturated.
//
// Input channel: i_valid / o_stall carry i_tap_time; a transfer happens at
// a clock edge with i_valid high and o_stall low. Output channel: o_valid /
// i_stall carry o_bpm_q8, o_status and o_taps_held, held in an output
// register until the receiver takes them.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 timeout_ticks, 1 ticks_per_minute); the user must write only while the
// block is idle, as the block itself does not enforce it.
// An item with fewer than two taps or a zero span skips the divider;
// otherwise the serial divider develops one quotient bit per cycle, for
// 32 + $clog2(MAX_TAPS) + 8 bits. One item is in work at a time: the next
// tap transfers only once the result is loaded into the output register.
// When the receiver stalls, the finished result waits in the output register
// and the next tap is still taken; a further result waits in the sequencer.
// Reset empties the tap history, clears o_valid and restores both
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_estimator
    import tte_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [TIME_W-1:0]     i_tap_time,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [BPM_W-1:0]      o_bpm_q8,
    output logic      [STAT_W-1:0]     o_status,
    output logic      [TAPS_W-1:0]     o_taps_held,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = TIME_W + IW;
    localparam int NUM_W = PROD_W + FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GAP  = 6'b000010,
        S_PREP = 6'b000100,
        S_SPAN = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [TIME_W-1:0] r_timeout;
    logic [TIME_W-1:0] r_tpm;
    logic [TIME_W-1:0] r_now;
    logic [NUM_W-1:0]  r_num;
    logic [STAT_W-1:0] r_res_status, n_res_status;

    logic              r_out_valid;
    logic [BPM_W-1:0]  r_out_bpm;
    logic [STAT_W-1:0] r_out_status;
    logic [TAPS_W-1:0] r_out_taps;

    t_win_cmd          w_cmd;
    logic [TIME_W-1:0] w_rd_data;
    logic [CW-1:0]     w_held;
    logic [TIME_W-1:0] w_diff;
    logic [CW-1:0]     w_nm1;
    logic [PROD_W-1:0] w_prod;
    logic              w_div_start;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quo;
    logic              w_out_load;
    logic [BPM_W-1:0]  w_bpm;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_tpm     <= TPM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TIME_W-1:0];
                CFG_TPM:     r_tpm     <= i_cfg_data[TIME_W-1:0];
                default:     ;
            endcase
        end
    end

    tte_window #(
        .MAX_TAPS (MAX_TAPS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_wr_data (r_now),
        .o_rd_data (w_rd_data),
        .o_held    (w_held)
    );

    tte_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (w_diff),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // gap or span against the timestamp just read from the window
    assign w_diff = r_now - w_rd_data;

    // scaled numerator: ticks_per_minute times (taps - 1)
    assign w_nm1  = w_held - CW'(1);
    assign w_prod = PROD_W'(r_tpm) * PROD_W'(w_nm1[IW-1:0]);

    // saturate the quotient to the result field
    assign w_bpm = (w_quo[NUM_W-1:BPM_W] != '0) ? BPM_MAX : w_quo[BPM_W-1:0];

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        w_cmd        = '0;
        w_div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                w_cmd.push  = 1'b1;
                w_cmd.clear = (w_held != '0) && (w_diff > r_timeout);
                n_state     = S_PREP;
            end
            S_PREP: begin
                w_cmd.rd_oldest = 1'b1;
                n_state         = S_SPAN;
            end
            S_SPAN: begin
                if (w_held < CW'(2)) begin
                    n_res_status = ST_NEED;
                    n_state      = S_DONE;
                end else if (w_diff == '0) begin
                    n_res_status = ST_ZERO;
                    n_state      = S_DONE;
                end else begin
                    n_res_status = ST_VALID;
                    w_div_start  = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // read the newest timestamp while the tap transfers
        if (r_state == S_IDLE) begin
            w_cmd.rd_newest = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the tap, the numerator and the pending status
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_now <= i_tap_time;
        end
        if (r_state == S_PREP) begin
            r_num <= {w_prod, {FRAC_BITS{1'b0}}};
        end
        r_res_status <= n_res_status;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_bpm    <= (r_res_status == ST_VALID) ? w_bpm : '0;
            r_out_status <= r_res_status;
            r_out_taps   <= TAPS_W'(w_held);
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_bpm_q8    = r_out_bpm;
    assign o_status    = r_out_status;
    assign o_taps_held = r_out_taps;

endmodule

`default_nettype wire

### design/tte_window.sv
// ----------------------------------------------------------------------------
// tte_window: ring of the most recent tap timestamps
// Holds up to MAX_TAPS timestamps in a small memory with one registered
// read port, tracks the oldest slot and the fill count, and pushes a new
// tap, optionally after emptying the history.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_window
    import tte_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_win_cmd                      i_cmd,
    input  wire logic [TIME_W-1:0]             i_wr_data,
    output logic      [TIME_W-1:0]             o_rd_data,
    output logic      [$clog2(MAX_TAPS+1)-1:0] o_held
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);

    logic [TIME_W-1:0] r_mem [MAX_TAPS];
    logic [TIME_W-1:0] r_rd_data;
    logic [IW-1:0]     r_oldest, n_oldest;
    logic [CW-1:0]     r_held, n_held;

    logic [IW-1:0] w_newest;
    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_wr_addr;
    logic [IW-1:0] w_eff_old;
    logic [CW-1:0] w_eff_held;

    // reduce a sum below twice the depth to a slot index
    function automatic logic [IW-1:0] wrap(input logic [CW:0] s);
        logic [CW:0] r;
        begin
            r = (s >= (CW+1)'(MAX_TAPS)) ? s - (CW+1)'(MAX_TAPS) : s;
            wrap = r[IW-1:0];
        end
    endfunction

    // locate the newest held timestamp
    always_comb begin
        if (r_held == '0) begin
            w_newest = '0;
        end else begin
            w_newest = wrap((CW+1)'(r_oldest) + (CW+1)'(r_held - CW'(1)));
        end
        w_rd_addr = i_cmd.rd_newest ? w_newest : r_oldest;
    end

    // push: empty first on timeout, then append or overwrite the oldest
    always_comb begin
        w_eff_old  = i_cmd.clear ? '0 : r_oldest;
        w_eff_held = i_cmd.clear ? '0 : r_held;
        n_oldest   = r_oldest;
        n_held     = r_held;
        w_wr_addr  = w_eff_old;
        if (i_cmd.push) begin
            if (w_eff_held < CW'(MAX_TAPS)) begin
                w_wr_addr = wrap((CW+1)'(w_eff_old) + (CW+1)'(w_eff_held));
                n_held    = w_eff_held + CW'(1);
                n_oldest  = w_eff_old;
            end else begin
                w_wr_addr = w_eff_old;
                n_held    = w_eff_held;
                n_oldest  = wrap((CW+1)'(w_eff_old) + (CW+1)'(1));
            end
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_held   <= '0;
        end else begin
            r_oldest <= n_oldest;
            r_held   <= n_held;
        end
    end

    // timestamp memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd_newest || i_cmd.rd_oldest) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_held    = r_held;

endmodule

`default_nettype wire

### design/tte_divider.sv
// ----------------------------------------------------------------------------
// tte_divider: bit-serial restoring divider
// Develops one quotient bit per cycle. The dividend shifts out of the
// quotient register from the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_divider
    import tte_pkg::*;
#(
    parameter int NUM_W = 43
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [TIME_W-1:0] i_den,
    output logic                   o_done,
    output logic      [NUM_W-1:0]  o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_quo;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [TIME_W:0]   w_trial;
    logic [TIME_W:0]   w_diff;
    logic              w_bit;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_bit   = (w_trial >= {1'b0, r_den});
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: load, then shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_bit};
            r_rem <= w_bit ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(1));
    assign o_quo  = r_quo;

endmodule

`default_nettype wire
